[sv/gah_pkg.sv]
// ----------------------------------------------------------------------------
// gah_pkg
// Types, widths and constants shared by the glucose alarm and its channels.
// ----------------------------------------------------------------------------
package gah_pkg;

  localparam int unsigned NowW     = 32;
  localparam int unsigned GlucoseW = 10;
  localparam int unsigned LevelW   = 10;
  localparam int unsigned SnoozeW  = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 10;
  localparam int unsigned PatternW = 2;

  localparam logic [NowW-1:0]    GeneralCooldownSec = NowW'(60);
  localparam logic [NowW-1:0]    UrgentCooldownSec  = NowW'(120);
  localparam logic [LevelW:0]    ClearMargin        = (LevelW + 1)'(8);

  typedef enum logic {
    MODE_CHECK  = 1'b0,
    MODE_SNOOZE = 1'b1
  } mode_e;

  typedef enum logic [PatternW-1:0] {
    PAT_NONE   = 2'd0,
    PAT_LOW    = 2'd1,
    PAT_HIGH   = 2'd2,
    PAT_URGENT = 2'd3
  } pattern_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_URGENT_LOW_LEVEL = 3'd0,
    CFG_LOW_LEVEL        = 3'd1,
    CFG_HIGH_LEVEL       = 3'd2,
    CFG_LOW_ENABLE       = 3'd3,
    CFG_HIGH_ENABLE      = 3'd4,
    CFG_SNOOZE_MINUTES   = 3'd5
  } cfg_idx_e;

  localparam logic [LevelW-1:0]  UrgentLowLevelRst = LevelW'(55);
  localparam logic [LevelW-1:0]  LowLevelRst       = LevelW'(70);
  localparam logic [LevelW-1:0]  HighLevelRst      = LevelW'(180);
  localparam logic [SnoozeW-1:0] SnoozeMinutesRst  = SnoozeW'(30);

endpackage

[sv/gah_in_if.sv]
// ----------------------------------------------------------------------------
// gah_in_if
// Input channel: one glucose check or snooze press per item.
// ----------------------------------------------------------------------------
interface gah_in_if;
  import gah_pkg::*;

  logic                valid;
  logic                ready;
  logic                mode;
  logic [NowW-1:0]     now_sec;
  logic [GlucoseW-1:0] glucose;
  logic                stale;

  modport source (output valid, output mode, output now_sec, output glucose,
                  output stale, input ready);
  modport sink   (input valid, input mode, input now_sec, input glucose,
                  input stale, output ready);
endinterface

[sv/gah_out_if.sv]
// ----------------------------------------------------------------------------
// gah_out_if
// Result channel: alert pattern and any-active flag per item.
// ----------------------------------------------------------------------------
interface gah_out_if;
  import gah_pkg::*;

  logic                valid;
  logic                ready;
  logic [PatternW-1:0] pattern;
  logic                any_active;

  modport source (output valid, output pattern, output any_active, input ready);
  modport sink   (input valid, input pattern, input any_active, output ready);
endinterface

[sv/glucose_alarm_with_hysteresis.sv]
// ----------------------------------------------------------------------------
// glucose_alarm_with_hysteresis
// Glucose threshold alarm with hysteresis, cooldowns and snooze.
// ----------------------------------------------------------------------------
// Usage:
//   in_if carries one item per handshake: a glucose check (mode 0) or a
//   snooze press (mode 1), each stamped with the current time in seconds.
//   out_if returns exactly one result per item, in order: the alert pattern
//   raised by that item and whether any alert flag is set afterwards.
//   cfg_we_i/cfg_idx_i/cfg_wdata_i write the six settings; write only while
//   no item is in flight.
//   Result valid follows the input handshake: the item waits in the input
//   register, then the alarm decision is evaluated against the state and
//   lands in the result register once that register can advance.
//   One item per cycle unless the receiver stalls; state updates in the
//   same cycle as the decision, so the next item sees it without a gap.
//   Reset clears all timers and flags and loads the default thresholds.
//   When the receiver stalls, the result register holds and the input
//   register fills; in_if.ready drops only when both are occupied.
// ----------------------------------------------------------------------------
module glucose_alarm_with_hysteresis (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  gah_in_if.sink                  in_if,
  gah_out_if.source               out_if,
  input  logic                    cfg_we_i,
  input  logic [gah_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [gah_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import gah_pkg::*;

  // configuration
  logic [LevelW-1:0]  urgent_level_q, low_level_q, high_level_q;
  logic               low_en_q, high_en_q;
  logic [SnoozeW-1:0] snooze_min_q;

  // input register
  logic                s1_valid_q;
  logic                s1_mode_q;
  logic [NowW-1:0]     s1_now_q;
  logic [GlucoseW-1:0] s1_glucose_q;
  logic                s1_stale_q;

  // alarm state
  logic [NowW-1:0] snooze_end_q, snooze_end_d;
  logic [NowW-1:0] last_urg_q, last_urg_d;
  logic [NowW-1:0] last_any_q, last_any_d;
  logic            high_flag_q, high_flag_d;
  logic            low_flag_q, low_flag_d;
  logic            urg_flag_q, urg_flag_d;

  // result register
  logic                out_valid_q;
  logic [PatternW-1:0] out_pattern_q;
  logic                out_any_q;
  pattern_e            pattern_d;

  logic advance, s1_fire;
  logic snoozed, check_ok, urg_hit, urg_ok, any_ok;
  logic low_hit, low_clr, high_hit, high_clr;
  logic [SnoozeW+5:0] snooze_len;

  assign advance     = !out_valid_q || out_if.ready;
  assign s1_fire     = s1_valid_q && advance;
  assign in_if.ready = !s1_valid_q || advance;

  assign out_if.valid      = out_valid_q;
  assign out_if.pattern    = out_pattern_q;
  assign out_if.any_active = out_any_q;

  // minutes * 60 as (m << 6) - (m << 2)
  assign snooze_len = {snooze_min_q, 6'd0} - {4'd0, snooze_min_q, 2'd0};

  assign snoozed  = s1_now_q < snooze_end_q;
  assign check_ok = !snoozed && (s1_glucose_q != '0) && !s1_stale_q;
  assign urg_hit  = s1_glucose_q <= urgent_level_q;
  assign urg_ok   = (s1_now_q - last_urg_q) >= UrgentCooldownSec;
  assign any_ok   = (s1_now_q - last_any_q) >= GeneralCooldownSec;
  assign low_hit  = low_en_q && (s1_glucose_q <= low_level_q);
  assign low_clr  = {1'b0, s1_glucose_q} > ({1'b0, low_level_q} + ClearMargin);
  assign high_hit = high_en_q && (s1_glucose_q >= high_level_q);
  assign high_clr = ({1'b0, high_level_q} >= ClearMargin) &&
                    ({1'b0, s1_glucose_q} < ({1'b0, high_level_q} - ClearMargin));

  always_comb begin
    snooze_end_d = snooze_end_q;
    last_urg_d   = last_urg_q;
    last_any_d   = last_any_q;
    high_flag_d  = high_flag_q;
    low_flag_d   = low_flag_q;
    urg_flag_d   = urg_flag_q;
    pattern_d    = PAT_NONE;
    if (s1_mode_q == MODE_SNOOZE) begin
      snooze_end_d = s1_now_q + NowW'(snooze_len);
      high_flag_d  = 1'b0;
      low_flag_d   = 1'b0;
      urg_flag_d   = 1'b0;
    end else if (check_ok) begin
      if (urg_hit) begin
        if (urg_ok) begin
          urg_flag_d = 1'b1;
          last_urg_d = s1_now_q;
          last_any_d = s1_now_q;
          pattern_d  = PAT_URGENT;
        end
      end else begin
        urg_flag_d = 1'b0;
        if (any_ok) begin
          if (low_hit) begin
            if (!low_flag_q) begin
              low_flag_d = 1'b1;
              last_any_d = s1_now_q;
              pattern_d  = PAT_LOW;
            end
          end else begin
            if (low_clr) begin
              low_flag_d = 1'b0;
            end
            if (high_hit) begin
              if (!high_flag_q) begin
                high_flag_d = 1'b1;
                last_any_d  = s1_now_q;
                pattern_d   = PAT_HIGH;
              end
            end else if (high_clr) begin
              high_flag_d = 1'b0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      urgent_level_q <= UrgentLowLevelRst;
      low_level_q    <= LowLevelRst;
      high_level_q   <= HighLevelRst;
      low_en_q       <= 1'b1;
      high_en_q      <= 1'b1;
      snooze_min_q   <= SnoozeMinutesRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_URGENT_LOW_LEVEL: urgent_level_q <= cfg_wdata_i[LevelW-1:0];
        CFG_LOW_LEVEL:        low_level_q    <= cfg_wdata_i[LevelW-1:0];
        CFG_HIGH_LEVEL:       high_level_q   <= cfg_wdata_i[LevelW-1:0];
        CFG_LOW_ENABLE:       low_en_q       <= cfg_wdata_i[0];
        CFG_HIGH_ENABLE:      high_en_q      <= cfg_wdata_i[0];
        CFG_SNOOZE_MINUTES:   snooze_min_q   <= cfg_wdata_i[SnoozeW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.ready && in_if.valid) begin
      s1_mode_q    <= in_if.mode;
      s1_now_q     <= in_if.now_sec;
      s1_glucose_q <= in_if.glucose;
      s1_stale_q   <= in_if.stale;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snooze_end_q <= '0;
      last_urg_q   <= '0;
      last_any_q   <= '0;
      high_flag_q  <= 1'b0;
      low_flag_q   <= 1'b0;
      urg_flag_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
      if (s1_fire) begin
        snooze_end_q <= snooze_end_d;
        last_urg_q   <= last_urg_d;
        last_any_q   <= last_any_d;
        high_flag_q  <= high_flag_d;
        low_flag_q   <= low_flag_d;
        urg_flag_q   <= urg_flag_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_pattern_q <= pattern_d;
      out_any_q     <= high_flag_d || low_flag_d || urg_flag_d;
    end
  end

endmodule
